FILE: design/shn_pkg.sv
// Shared constants, codes and controller/datapath interface types of the histogram normalizer.
`timescale 1ns / 1ps
package shn_pkg;

  localparam int BINS  = 16;
  localparam int IDX_W = $clog2(BINS);
  localparam int CNT_W = $clog2(BINS + 1);
  localparam int SUM_W = 32 + IDX_W;
  localparam int NUM_W = 49;
  localparam int Q_W   = 17;

  // Reset contents: uniform over the reset bin count.
  localparam int RST_N = (BINS < 16) ? BINS : 16;
  localparam int RST_U = (65536 + RST_N / 2) / RST_N;

  // Reciprocal of ten in 2^-23 units for the smoothing divide.
  localparam logic [19:0] RECIP10 = 20'd838861;

  localparam logic [2:0] KIND_CLEAR   = 3'd0;
  localparam logic [2:0] KIND_ACCUM   = 3'd1;
  localparam logic [2:0] KIND_NORM    = 3'd2;
  localparam logic [2:0] KIND_READ    = 3'd3;
  localparam logic [2:0] KIND_UNIFORM = 3'd4;

  localparam logic REG_EPSILON     = 1'b0;
  localparam logic REG_BINS_IN_USE = 1'b1;

  typedef struct packed {
    logic accept;
    logic idx_clr;
    logic idx_inc;
    logic sweep_wr;
    logic sum_add;
    logic set_err;
    logic div_load;
    logic div_step;
    logic smooth_wr;
    logic last_wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       sum_zero;
    logic       idx_last;
    logic       sweep_last;
    logic       div_done;
    logic       out_free;
  } status_t;

endpackage

FILE: design/smoothed_histogram_normalizer.sv
// Top level of the smoothed histogram normalizer: controller plus datapath.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     kind, bin, amount
//   out      output     out_valid / out_stall   value, normalized, error
//   cfg      input      cfg_write               cfg_index, cfg_data
//
// One word is handled at a time. Read, accumulate and unknown kinds go straight
// to the final state, clear sweeps every bin, uniform runs one divide and then
// the sweep, and normalize sums the n active bins, then divides and smooths each.
// The shared restoring divider produces one quotient bit per cycle, 17 bits per bin.
// Reset is synchronous and restores the registers and a uniform store.
// A stall on the output only holds the result register; the next word is accepted
// while that result still waits, and its own result waits in the final state.
`timescale 1ns / 1ps
module smoothed_histogram_normalizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [3:0]  bin,
  input  logic [23:0] amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] value,
  output logic        normalized,
  output logic        error
);
  import shn_pkg::*;

  // Commands flow from the state machine; status flows back from the datapath.
  cmd_t    cmd;
  status_t st;

  shn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  shn_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .bin        (bin),
    .amount     (amount),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .normalized (normalized),
    .error      (error),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

FILE: design/shn_ctrl.sv
// Sequencing state machine of the histogram normalizer.
`timescale 1ns / 1ps
module shn_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  shn_pkg::status_t st,
  output shn_pkg::cmd_t   cmd
);
  import shn_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SWEEP  = 4'd2;
  localparam logic [3:0] S_SUM    = 4'd3;
  localparam logic [3:0] S_DLOAD  = 4'd4;
  localparam logic [3:0] S_DSTEP  = 4'd5;
  localparam logic [3:0] S_SMOOTH = 4'd6;
  localparam logic [3:0] S_LAST   = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (st.kind)
          KIND_CLEAR:   state_next = S_SWEEP;
          KIND_NORM:    state_next = S_SUM;
          KIND_UNIFORM: state_next = S_DLOAD;
          default:      state_next = S_FIN;
        endcase
      end
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (st.sweep_last) state_next = S_FIN;
      end
      S_SUM: begin
        cmd.sum_add = 1'b1;
        if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_DLOAD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DLOAD: begin
        if (st.kind == KIND_NORM && st.sum_zero) begin
          cmd.set_err = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.div_load = 1'b1;
          state_next   = S_DSTEP;
        end
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        if (st.div_done) begin
          state_next = (st.kind == KIND_UNIFORM) ? S_SWEEP : S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        cmd.smooth_wr = 1'b1;
        if (st.idx_last) begin
          state_next = S_LAST;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_DLOAD;
        end
      end
      S_LAST: begin
        cmd.last_wr = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/shn_datapath.sv
// Bin store, configuration registers, sum, shared divider, smoothing and output register.
`timescale 1ns / 1ps
module shn_datapath (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data,
  input  logic [2:0]      kind,
  input  logic [3:0]      bin,
  input  logic [23:0]     amount,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     value,
  output logic            normalized,
  output logic            error,
  input  shn_pkg::cmd_t   cmd,
  output shn_pkg::status_t st
);
  import shn_pkg::*;

  logic [15:0]      epsilon;
  logic [4:0]       bins_in_use;
  logic [31:0]      store [BINS];
  logic [2:0]       kind_r;
  logic [3:0]       bin_r;
  logic [23:0]      amount_r;
  logic [IDX_W-1:0] idx;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] rem;
  logic [16:0]      nlow;
  logic [4:0]       dcnt;
  logic [Q_W-1:0]   q;
  logic [Q_W-1:0]   prev;
  logic [Q_W-1:0]   prev2;
  logic             err_f;
  logic             norm;

  logic [CNT_W-1:0] n;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      rd;
  logic [32:0]      tsum;
  logic [31:0]      t;
  logic [NUM_W-1:0] num;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   den;
  logic             qbit;
  logic             bin_ok;
  logic [Q_W-1:0]   sm_self;
  logic [Q_W-1:0]   sm_left;
  logic [Q_W-1:0]   sm_right;
  logic [19:0]      sm_x;
  logic [39:0]      sm_prod;
  logic [31:0]      sm_val;
  logic [32:0]      acc_sum;
  logic [31:0]      acc_val;
  logic             norm_next;
  logic             err_out;

  // Active bin count, clamped to 1..BINS.
  always_comb begin
    if (bins_in_use == 5'd0) begin
      n = CNT_W'(1);
    end else if (32'(bins_in_use) > 32'(BINS)) begin
      n = CNT_W'(BINS);
    end else begin
      n = CNT_W'(bins_in_use);
    end
  end

  assign bin_ok  = (32'(bin_r) < 32'(n));
  assign rd_addr = cmd.finish ? IDX_W'(bin_r) : idx;
  assign rd      = store[rd_addr];
  assign tsum    = {1'b0, rd} + 33'(epsilon);
  assign t       = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];

  always_comb begin
    if (kind_r == KIND_UNIFORM) begin
      num = NUM_W'(17'h10000) + NUM_W'(n >> 1);
      den = (SUM_W + 1)'(n);
    end else begin
      num = NUM_W'({t, 16'd0}) + NUM_W'(sum >> 1);
      den = {1'b0, sum};
    end
  end

  assign trial = {rem, nlow[16]};
  assign qbit  = (trial >= den);

  // Smoothing: (8*self + left + right + 5) / 10, a missing neighbor replaced by self.
  always_comb begin
    sm_self = prev;
    if (cmd.last_wr) begin
      sm_left  = (n == CNT_W'(1)) ? prev : prev2;
      sm_right = prev;
    end else begin
      sm_left  = (idx == IDX_W'(1)) ? prev : prev2;
      sm_right = q;
    end
    sm_x    = {sm_self, 3'b000} + 20'(sm_left) + 20'(sm_right) + 20'd5;
    sm_prod = sm_x * RECIP10;
    sm_val  = 32'(sm_prod[39:23]);
  end

  assign acc_sum = {1'b0, rd} + 33'(amount_r);
  assign acc_val = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];

  always_comb begin
    norm_next = norm;
    err_out   = 1'b0;
    case (kind_r)
      KIND_CLEAR: norm_next = 1'b0;
      KIND_ACCUM: begin
        err_out = !bin_ok;
        if (bin_ok) norm_next = 1'b0;
      end
      KIND_NORM: begin
        err_out = err_f;
        if (!err_f) norm_next = 1'b1;
      end
      KIND_READ:    err_out   = !bin_ok;
      KIND_UNIFORM: norm_next = 1'b1;
      default: ;
    endcase
  end

  assign st.kind       = kind_r;
  assign st.sum_zero   = (sum == '0);
  assign st.idx_last   = (CNT_W'(idx) == n - CNT_W'(1));
  assign st.sweep_last = (idx == IDX_W'(BINS - 1));
  assign st.div_done   = (dcnt == 5'd0);
  assign st.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon     <= 16'd1;
      bins_in_use <= 5'd16;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EPSILON:     epsilon     <= cfg_data;
        REG_BINS_IN_USE: bins_in_use <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BINS; i++) begin
        store[i] <= (i < RST_N) ? 32'(RST_U) : 32'd0;
      end
    end else if (cmd.sweep_wr) begin
      store[idx] <= (kind_r == KIND_UNIFORM && CNT_W'(idx) < n) ? 32'(q) : 32'd0;
    end else if (cmd.smooth_wr && idx != '0) begin
      store[idx - IDX_W'(1)] <= sm_val;
    end else if (cmd.last_wr) begin
      store[IDX_W'(n - CNT_W'(1))] <= sm_val;
    end else if (cmd.finish && kind_r == KIND_ACCUM && bin_ok) begin
      store[IDX_W'(bin_r)] <= acc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r   <= kind;
      bin_r    <= bin;
      amount_r <= amount;
    end
    if (cmd.accept || cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.accept) begin
      sum <= '0;
    end else if (cmd.sum_add) begin
      sum <= sum + SUM_W'(t);
    end
    if (cmd.div_load) begin
      rem  <= SUM_W'(num[NUM_W-1:17]);
      nlow <= num[16:0];
      dcnt <= 5'd16;
      q    <= '0;
    end else if (cmd.div_step) begin
      rem  <= qbit ? SUM_W'(trial - den) : SUM_W'(trial);
      nlow <= {nlow[15:0], 1'b0};
      dcnt <= dcnt - 5'd1;
      q    <= {q[Q_W-2:0], qbit};
    end
    if (cmd.smooth_wr) begin
      prev2 <= prev;
      prev  <= q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_f     <= 1'b0;
      norm      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        err_f <= 1'b0;
      end else if (cmd.set_err) begin
        err_f <= 1'b1;
      end
      if (cmd.finish) begin
        norm      <= norm_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      value      <= (kind_r == KIND_READ && bin_ok) ? rd : 32'd0;
      normalized <= norm_next;
      error      <= err_out;
    end
  end

endmodule

FILE: design/shn_checker.sv
// Port-level checks of the histogram normalizer and their attachment to the top level.
`timescale 1ns / 1ps
module shn_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] value,
  input logic        error
);

  // A held result keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value))
    else $error("output word changed while stalled");

  // One word at a time: an accepted word makes the block busy next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a word was in progress");

  // A flagged result never carries bin content.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> value == 32'd0)
    else $error("error result with nonzero value");

endmodule

bind smoothed_histogram_normalizer shn_checker u_chk (.*);

FILE: bench/smoothed_histogram_normalizer_test.sv
// Self-checking testbench for the smoothed histogram normalizer.
`timescale 1ns / 1ps
module smoothed_histogram_normalizer_test;
  import shn_pkg::*;

  // Clock, reset and the block's ports.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_EPSILON;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = KIND_CLEAR;
  logic [3:0]  bin = '0;
  logic [23:0] amount = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] value;
  logic        normalized;
  logic        error;

  smoothed_histogram_normalizer dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .bin(bin), .amount(amount),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .normalized(normalized), .error(error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One result word as the block presents it.
  typedef struct packed {
    logic [31:0] value;
    logic        normalized;
    logic        error;
  } result_t;

  // One stimulus word; a directed row may also carry a typed-in result.
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  bin;
    logic [23:0] amount;
    logic        fixed;
    result_t     res;
  } row_t;

  // The predictor's own copy of the registers and the bin store.
  logic [31:0] hist [BINS];
  logic        hist_norm;
  logic [15:0] eps_reg;
  logic [4:0]  nbins_reg;

  result_t pending_results [$];
  int      mismatches = 0;
  int      cycles = 0;

  // Idling rates in percent, changed between phases.
  int send_idle = 0;
  int recv_idle = 0;
  bit long_hold = 1'b0;

  function automatic int active_bins();
    int n;
    n = int'(nbins_reg);
    if (n == 0) n = 1;
    if (n > BINS) n = BINS;
    return n;
  endfunction

  function automatic void fill_uniform();
    int n;
    logic [31:0] u;
    n = active_bins();
    u = 32'((65536 + n / 2) / n);
    for (int i = 0; i < BINS; i++) hist[i] = (i < n) ? u : 32'd0;
    hist_norm = 1'b1;
  endfunction

  // Epsilon added to each bin, rounded divide by the sum, then the three-tap smoothing.
  // Returns 1 when the sum is zero, in which case nothing changes.
  function automatic bit normalize_hist();
    int n;
    logic [63:0] t [BINS];
    logic [63:0] p [BINS];
    logic [63:0] s;
    n = active_bins();
    s = 0;
    for (int i = 0; i < n; i++) begin
      t[i] = 64'(hist[i]) + 64'(eps_reg);
      if (t[i] > 64'hFFFF_FFFF) t[i] = 64'hFFFF_FFFF;
      s += t[i];
    end
    if (s == 0) return 1'b1;
    for (int i = 0; i < n; i++) p[i] = ((t[i] << 16) + s / 2) / s;
    if (n > 1) begin
      hist[0] = 32'((9 * p[0] + p[1] + 5) / 10);
      hist[n-1] = 32'((9 * p[n-1] + p[n-2] + 5) / 10);
      for (int i = 1; i + 1 < n; i++)
        hist[i] = 32'((8 * p[i] + p[i-1] + p[i+1] + 5) / 10);
    end else begin
      hist[0] = 32'(p[0]);
    end
    hist_norm = 1'b1;
    return 1'b0;
  endfunction

  // Advances the predictor by one accepted word and returns its result.
  function automatic result_t predict_histogram(logic [2:0] k, logic [3:0] b,
                                                logic [23:0] a);
    result_t r;
    logic [32:0] v;
    int n;
    n = active_bins();
    r = '0;
    case (k)
      KIND_CLEAR: begin
        for (int i = 0; i < BINS; i++) hist[i] = '0;
        hist_norm = 1'b0;
      end
      KIND_ACCUM: begin
        if (b >= n) begin
          r.error = 1'b1;
        end else begin
          v = 33'(hist[b]) + 33'(a);
          hist[b] = v[32] ? 32'hFFFF_FFFF : v[31:0];
          hist_norm = 1'b0;
        end
      end
      KIND_NORM: r.error = normalize_hist();
      KIND_READ: begin
        if (b >= n) r.error = 1'b1;
        else r.value = hist[b];
      end
      KIND_UNIFORM: fill_uniform();
      default: ;
    endcase
    r.normalized = hist_norm;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Result checking: every accepted result word against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", value, 32'd0);
      end else begin
        result_t want;
        want = pending_results.pop_front();
        if (value !== want.value) report_mismatch("value", value, want.value);
        if (normalized !== want.normalized)
          report_mismatch("normalized", 32'(normalized), 32'(want.normalized));
        if (error !== want.error) report_mismatch("error", 32'(error), 32'(want.error));
      end
    end
  end

  // Receiver stalls, plus one long hold-off counted here while the sender keeps going.
  always @(posedge clk) begin
    int hold;
    if (long_hold) begin
      out_stall <= 1'b1;
      for (hold = 0; hold < 400; hold++) @(posedge clk);
      long_hold = 1'b0;
    end
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // Cycle limit: a run that passes it is stopped and reported as failed.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 4000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one word and waits for it to be accepted; idles first at random.
  // Valid stays high on return so that the next word can follow directly.
  task automatic send_word(logic [2:0] k, logic [3:0] b, logic [23:0] a,
                           bit fixed, result_t want);
    result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    bin <= b;
    amount <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_histogram(k, b, a);
    // A typed-in row is checked against the value read off by hand.
    if (fixed) r = want;
    pending_results = {pending_results, r};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // A quiet gap before any register write.
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_EPSILON) eps_reg = d;
    else nbins_reg = d[4:0];
  endtask

  // Directed table. Rows with fixed set carry results that follow directly.
  localparam int DIR_N = 22;
  row_t directed [DIR_N];

  initial begin
    directed[0]  = '{KIND_READ,    4'd0,  24'd0, 1'b1, '{32'd4096, 1'b1, 1'b0}};
    directed[1]  = '{KIND_READ,    4'd15, 24'd0, 1'b1, '{32'd4096, 1'b1, 1'b0}};
    directed[2]  = '{KIND_CLEAR,   4'd0,  24'd0, 1'b1, '{32'd0,    1'b0, 1'b0}};
    directed[3]  = '{KIND_READ,    4'd7,  24'd0, 1'b1, '{32'd0,    1'b0, 1'b0}};
    directed[4]  = '{KIND_ACCUM,   4'd0,  24'hFFFFFF, 1'b1, '{32'd0, 1'b0, 1'b0}};
    directed[5]  = '{KIND_ACCUM,   4'd15, 24'h000001, 1'b0, '0};
    directed[6]  = '{KIND_ACCUM,   4'd7,  24'h123456, 1'b0, '0};
    directed[7]  = '{KIND_NORM,    4'd0,  24'd0, 1'b0, '0};
    directed[8]  = '{KIND_READ,    4'd0,  24'd0, 1'b0, '0};
    directed[9]  = '{KIND_READ,    4'd14, 24'd0, 1'b0, '0};
    directed[10] = '{KIND_READ,    4'd15, 24'd0, 1'b0, '0};
    directed[11] = '{KIND_UNIFORM, 4'd0,  24'd0, 1'b1, '{32'd0, 1'b1, 1'b0}};
    directed[12] = '{3'd5,         4'd3,  24'd77, 1'b0, '0};
    directed[13] = '{3'd6,         4'd0,  24'd0, 1'b0, '0};
    directed[14] = '{3'd7,         4'd15, 24'hFFFFFF, 1'b0, '0};
    directed[15] = '{KIND_CLEAR,   4'd0,  24'd0, 1'b0, '0};
    directed[16] = '{KIND_NORM,    4'd0,  24'd0, 1'b0, '0};
    // Two large accumulates into one bin, read back before and after a normalize.
    directed[17] = '{KIND_ACCUM,   4'd3,  24'hFFFFFF, 1'b0, '0};
    directed[18] = '{KIND_ACCUM,   4'd3,  24'hFFFFFF, 1'b0, '0};
    directed[19] = '{KIND_READ,    4'd3,  24'd0, 1'b0, '0};
    directed[20] = '{KIND_NORM,    4'd0,  24'd0, 1'b0, '0};
    directed[21] = '{KIND_READ,    4'd3,  24'd0, 1'b0, '0};
  end

  // A random word: mostly accumulates and reads, some normalizes, and rarer clears, uniforms and unknown kinds.
  task automatic send_random();
    int pick;
    logic [2:0] k;
    logic [23:0] a;
    pick = $urandom_range(99);
    if (pick < 45) k = KIND_ACCUM;
    else if (pick < 75) k = KIND_READ;
    else if (pick < 87) k = KIND_NORM;
    else if (pick < 92) k = KIND_CLEAR;
    else if (pick < 96) k = KIND_UNIFORM;
    else k = 3'($urandom_range(7, 5));
    case ($urandom_range(3))
      0: a = 24'($urandom);
      1: a = 24'hFFFFFF - 24'($urandom_range(3));
      default: a = 24'($urandom_range(65535));
    endcase
    send_word(k, 4'($urandom), a, 1'b0, '0);
  endtask

  initial begin
    // Reset state of the predictor follows the reset of the block.
    eps_reg = 16'd1;
    nbins_reg = 5'd16;
    fill_uniform();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk under the reset settings.
    for (int i = 0; i < DIR_N; i++)
      send_word(directed[i].kind, directed[i].bin, directed[i].amount,
                directed[i].fixed, directed[i].res);
    drain();

    // Zero epsilon on a cleared store exposes the zero-sum case.
    write_reg(REG_EPSILON, 16'd0);
    send_word(KIND_CLEAR, 4'd0, 24'd0, 1'b0, '0);
    send_word(KIND_NORM, 4'd0, 24'd0, 1'b1, '{32'd0, 1'b0, 1'b1});
    drain();

    // Single active bin: a bad bin index, and normalize without smoothing.
    write_reg(REG_BINS_IN_USE, 16'd1);
    write_reg(REG_EPSILON, 16'hFFFF);
    send_word(KIND_UNIFORM, 4'd0, 24'd0, 1'b0, '0);
    send_word(KIND_READ, 4'd1, 24'd0, 1'b1, '{32'd0, 1'b1, 1'b1});
    send_word(KIND_ACCUM, 4'd9, 24'd5, 1'b1, '{32'd0, 1'b1, 1'b1});
    send_word(KIND_ACCUM, 4'd0, 24'd5, 1'b0, '0);
    send_word(KIND_NORM, 4'd0, 24'd0, 1'b0, '0);
    send_word(KIND_READ, 4'd0, 24'd0, 1'b1, '{32'd65536, 1'b1, 1'b0});
    drain();

    // Random phases across several settings, with the idling mix changed every two phases.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_BINS_IN_USE, 16'd16); write_reg(REG_EPSILON, 16'd1); end
        1: begin write_reg(REG_BINS_IN_USE, 16'd0); write_reg(REG_EPSILON, 16'd300); end
        2: begin write_reg(REG_BINS_IN_USE, 16'd31); write_reg(REG_EPSILON, 16'hFFFF); end
        3: begin write_reg(REG_BINS_IN_USE, 16'd2); write_reg(REG_EPSILON, 16'd0); end
        4: begin write_reg(REG_BINS_IN_USE, 16'd5); write_reg(REG_EPSILON, 16'd17); end
        default: begin write_reg(REG_BINS_IN_USE, 16'd16); write_reg(REG_EPSILON, 16'd0); end
      endcase
      if (phase < 2) begin
        send_idle = 8; recv_idle = 45;
      end else if (phase < 4) begin
        send_idle = 45; recv_idle = 8;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      // The receiver holds off once while words keep coming.
      if (phase == 4) long_hold = 1'b1;
      for (int i = 0; i < 330; i++) send_random();
      drain();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
